// ===== rtl/tcpt_pkg.sv =====
// shared types, codes and constants of the trace cache probe table
package tcpt_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int PROBE_DEPTH_DEF   = 8;

    localparam int REQ_W     = 3;
    localparam int ADDR_W    = 52;
    localparam int MODE_W    = 32;
    localparam int TRACE_W   = 32;
    localparam int SEL_W     = 10;
    localparam int OUTCOME_W = 2;
    localparam int PAGE_SHIFT = 12;
    localparam int HASH_SHIFT = 4;

    localparam logic [REQ_W-1:0] REQ_LOOKUP     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_MARK       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FLUSH_ALL  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FLUSH_PAGE = 3'd4;

    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_DONE  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_FREE  = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [MODE_W-1:0]  mode;
        logic [TRACE_W-1:0] trace;
    } entry_t;

    typedef enum logic [2:0] {
        VW_NONE,
        VW_CLEAR,
        VW_MARK,
        VW_PAGE,
        VW_ALLOC
    } vw_t;

    typedef enum logic [1:0] {
        RES_DONE,
        RES_HIT,
        RES_ALLOC
    } res_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic ptr_inc;
        logic chk;
        vw_t  vw;
        logic res_load;
        res_t res;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic page_match;
    } st_t;

endpackage

// ===== rtl/tcpt_if.sv =====
// request and result channel interfaces
interface tcpt_req_if;
    logic                              valid;
    logic                              ready;
    logic [tcpt_pkg::REQ_W-1:0]        req_type;
    logic [tcpt_pkg::ADDR_W-1:0]       phys_addr;
    logic [tcpt_pkg::MODE_W-1:0]       fetch_mode;
    logic [tcpt_pkg::TRACE_W-1:0]      trace_mask;
    logic [tcpt_pkg::SEL_W-1:0]        slot_select;

    modport source (
        output valid, req_type, phys_addr, fetch_mode, trace_mask, slot_select,
        input  ready
    );
    modport sink (
        input  valid, req_type, phys_addr, fetch_mode, trace_mask, slot_select,
        output ready
    );
endinterface

interface tcpt_res_if;
    logic                              valid;
    logic                              ready;
    logic                              found;
    logic [tcpt_pkg::SEL_W-1:0]        slot_index;
    logic [tcpt_pkg::TRACE_W-1:0]      slot_trace_mask;
    logic [tcpt_pkg::OUTCOME_W-1:0]    outcome;

    modport source (
        output valid, found, slot_index, slot_trace_mask, outcome,
        input  ready
    );
    modport sink (
        input  valid, found, slot_index, slot_trace_mask, outcome,
        output ready
    );
endinterface

// ===== rtl/tcpt_ctrl.sv =====
// controller state machine of the probe table
module tcpt_ctrl #(
    parameter int TABLE_ENTRIES = tcpt_pkg::TABLE_ENTRIES_DEF,
    parameter int PROBE_DEPTH   = tcpt_pkg::PROBE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [tcpt_pkg::REQ_W-1:0] in_req_type,
    output logic                       out_valid,
    input  logic                       out_ready,
    output tcpt_pkg::cmd_t             cmd,
    input  tcpt_pkg::st_t              st
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W:0] CNT_LAST  = (IDX_W+1)'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W:0] CNT_ALL   = (IDX_W+1)'(TABLE_ENTRIES);
    localparam logic [IDX_W:0] CNT_PROBE = (IDX_W+1)'(PROBE_DEPTH);
    localparam logic [IDX_W:0] CNT_ONE   = (IDX_W+1)'(1);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_PROBE = 7'b0000100,
        S_MARK  = 7'b0001000,
        S_CLEAR = 7'b0010000,
        S_PAGE  = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t         state_reg, state_next;
    logic [IDX_W:0] cnt_reg, cnt_next;
    logic           pend_reg, pend_next;
    logic           is_alloc_reg, is_alloc_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_free;
    logic           last_chk;
    logic           stall;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        is_alloc_next = is_alloc_reg;
        cmd.load      = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.ptr_inc   = 1'b0;
        cmd.chk       = 1'b0;
        cmd.vw        = tcpt_pkg::VW_NONE;
        cmd.res_load  = 1'b0;
        cmd.res       = tcpt_pkg::RES_DONE;
        last_chk      = 1'b0;
        stall         = 1'b0;

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                cmd.vw      = tcpt_pkg::VW_CLEAR;
                cmd.ptr_inc = 1'b1;
                cnt_next    = cnt_reg + CNT_ONE;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_FIN;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    cnt_next      = '0;
                    pend_next     = 1'b0;
                    is_alloc_next = (in_req_type == tcpt_pkg::REQ_ALLOC);
                    case (in_req_type)
                        tcpt_pkg::REQ_LOOKUP,
                        tcpt_pkg::REQ_ALLOC:      state_next = S_PROBE;
                        tcpt_pkg::REQ_MARK:       state_next = S_MARK;
                        tcpt_pkg::REQ_FLUSH_ALL:  state_next = S_CLEAR;
                        tcpt_pkg::REQ_FLUSH_PAGE: state_next = S_PAGE;
                        default:                  state_next = S_FIN;
                    endcase
                end
            end
            S_PROBE:
            begin
                last_chk = pend_reg && (cnt_reg == CNT_PROBE);
                stall    = pend_reg && (st.match || last_chk) && !out_free;
                if (!stall)
                begin
                    if (cnt_reg < CNT_PROBE)
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.ptr_inc = 1'b1;
                        cnt_next    = cnt_reg + CNT_ONE;
                        pend_next   = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                    cmd.chk = pend_reg;
                    if (pend_reg && st.match)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res      = tcpt_pkg::RES_HIT;
                        state_next   = S_IDLE;
                    end
                    else if (last_chk)
                    begin
                        cmd.res_load = 1'b1;
                        state_next   = S_IDLE;
                        if (is_alloc_reg)
                        begin
                            cmd.vw  = tcpt_pkg::VW_ALLOC;
                            cmd.res = tcpt_pkg::RES_ALLOC;
                        end
                    end
                end
            end
            S_MARK:
            begin
                cmd.vw     = tcpt_pkg::VW_MARK;
                state_next = S_FIN;
            end
            S_PAGE:
            begin
                last_chk = pend_reg && (cnt_reg == CNT_ALL);
                if (cnt_reg < CNT_ALL)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.ptr_inc = 1'b1;
                    cnt_next    = cnt_reg + CNT_ONE;
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && st.page_match)
                begin
                    cmd.vw = tcpt_pkg::VW_PAGE;
                end
                if (last_chk)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            is_alloc_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            is_alloc_reg  <= is_alloc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/tcpt_dp.sv =====
// datapath of the probe table: entry and valid memories, compare, result register
module tcpt_dp #(
    parameter int TABLE_ENTRIES = tcpt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tcpt_pkg::cmd_t                 cmd,
    output tcpt_pkg::st_t                  st,
    input  logic [tcpt_pkg::REQ_W-1:0]     req_type,
    input  logic [tcpt_pkg::ADDR_W-1:0]    phys_addr,
    input  logic [tcpt_pkg::MODE_W-1:0]    fetch_mode,
    input  logic [tcpt_pkg::TRACE_W-1:0]   trace_mask,
    input  logic [tcpt_pkg::SEL_W-1:0]     slot_select,
    output logic                           found,
    output logic [tcpt_pkg::SEL_W-1:0]     slot_index,
    output logic [tcpt_pkg::TRACE_W-1:0]   slot_trace_mask,
    output logic [tcpt_pkg::OUTCOME_W-1:0] outcome
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int ADDR_W = tcpt_pkg::ADDR_W;
    localparam int PAGE_SHIFT = tcpt_pkg::PAGE_SHIFT;

    tcpt_pkg::entry_t data_mem [TABLE_ENTRIES];
    logic             valid_mem [TABLE_ENTRIES];

    logic [ADDR_W-1:0]             req_addr_reg;
    logic [tcpt_pkg::MODE_W-1:0]   req_mode_reg;
    logic [tcpt_pkg::TRACE_W-1:0]  req_trace_reg;
    logic [IDX_W-1:0]              home_reg;
    logic [IDX_W-1:0]              ptr_reg, ptr_next;
    logic [IDX_W-1:0]              rd_slot_reg;
    tcpt_pkg::entry_t              rd_entry_reg;
    logic                          rd_valid_reg;
    logic                          have_free_reg, have_free_next;
    logic [IDX_W-1:0]              open_slot_reg, open_slot_next;

    logic                          found_reg;
    logic [tcpt_pkg::SEL_W-1:0]    slot_index_reg;
    logic [tcpt_pkg::TRACE_W-1:0]  slot_trace_reg;
    logic [tcpt_pkg::OUTCOME_W-1:0] outcome_reg;

    logic [63:0]                   hash_full;
    logic [IDX_W-1:0]              in_home;
    logic [31:0]                   sel_full;
    logic [IDX_W-1:0]              in_sel;
    logic                          cur_free;
    logic                          free_now;
    logic [IDX_W-1:0]              open_slot_now;
    logic [IDX_W-1:0]              alloc_slot;
    logic                          v_we;
    logic [IDX_W-1:0]              v_addr;
    logic                          v_data;
    logic                          d_we;
    logic [31:0]                   hit_slot_w;
    logic [31:0]                   alloc_slot_w;

    assign hash_full = (64'(phys_addr) >> tcpt_pkg::HASH_SHIFT)
                     ^ (64'(phys_addr) >> PAGE_SHIFT) ^ 64'(fetch_mode);
    assign in_home   = hash_full[IDX_W-1:0];
    assign sel_full  = 32'(slot_select);
    assign in_sel    = sel_full[IDX_W-1:0];

    assign cur_free      = !rd_valid_reg;
    assign free_now      = have_free_reg || cur_free;
    assign open_slot_now = have_free_reg ? open_slot_reg : rd_slot_reg;
    assign alloc_slot    = free_now ? open_slot_now : home_reg;
    assign hit_slot_w    = 32'(rd_slot_reg);
    assign alloc_slot_w  = 32'(alloc_slot);

    assign st.match      = rd_valid_reg && (rd_entry_reg.addr == req_addr_reg)
                         && (rd_entry_reg.mode == req_mode_reg);
    assign st.page_match = rd_valid_reg
                         && (rd_entry_reg.addr[ADDR_W-1:PAGE_SHIFT]
                             == req_addr_reg[ADDR_W-1:PAGE_SHIFT]);

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.load)
        begin
            case (req_type)
                tcpt_pkg::REQ_LOOKUP,
                tcpt_pkg::REQ_ALLOC: ptr_next = in_home;
                tcpt_pkg::REQ_MARK:  ptr_next = in_sel;
                default:             ptr_next = '0;
            endcase
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        have_free_next = have_free_reg;
        open_slot_next = open_slot_reg;
        if (cmd.load)
        begin
            have_free_next = 1'b0;
        end
        else if (cmd.chk && !have_free_reg && cur_free)
        begin
            have_free_next = 1'b1;
            open_slot_next = rd_slot_reg;
        end
    end

    always_comb
    begin
        v_we   = 1'b0;
        v_addr = ptr_reg;
        v_data = 1'b0;
        d_we   = 1'b0;
        case (cmd.vw)
            tcpt_pkg::VW_CLEAR:
            begin
                v_we = 1'b1;
            end
            tcpt_pkg::VW_MARK:
            begin
                v_we   = 1'b1;
                v_data = 1'b1;
            end
            tcpt_pkg::VW_PAGE:
            begin
                v_we   = 1'b1;
                v_addr = rd_slot_reg;
            end
            tcpt_pkg::VW_ALLOC:
            begin
                v_we   = 1'b1;
                v_addr = alloc_slot;
                d_we   = 1'b1;
            end
            default:
            begin
                v_we = 1'b0;
            end
        endcase
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_entry_reg <= data_mem[ptr_reg];
        end
        if (d_we)
        begin
            data_mem[alloc_slot] <= '{addr: req_addr_reg, mode: req_mode_reg,
                                      trace: req_trace_reg};
        end
    end

    // valid memory
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_valid_reg <= valid_mem[ptr_reg];
        end
        if (v_we)
        begin
            valid_mem[v_addr] <= v_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_addr_reg  <= phys_addr;
            req_mode_reg  <= fetch_mode;
            req_trace_reg <= trace_mask;
            home_reg      <= in_home;
        end
        if (cmd.rd_en)
        begin
            rd_slot_reg <= ptr_reg;
        end
        open_slot_reg <= open_slot_next;
        if (cmd.res_load)
        begin
            case (cmd.res)
                tcpt_pkg::RES_HIT:
                begin
                    found_reg      <= 1'b1;
                    slot_index_reg <= hit_slot_w[tcpt_pkg::SEL_W-1:0];
                    slot_trace_reg <= rd_entry_reg.trace;
                    outcome_reg    <= tcpt_pkg::OUT_HIT;
                end
                tcpt_pkg::RES_ALLOC:
                begin
                    found_reg      <= 1'b0;
                    slot_index_reg <= alloc_slot_w[tcpt_pkg::SEL_W-1:0];
                    slot_trace_reg <= req_trace_reg;
                    outcome_reg    <= free_now ? tcpt_pkg::OUT_FREE : tcpt_pkg::OUT_EVICT;
                end
                default:
                begin
                    found_reg      <= 1'b0;
                    slot_index_reg <= '0;
                    slot_trace_reg <= '0;
                    outcome_reg    <= tcpt_pkg::OUT_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            have_free_reg <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            have_free_reg <= have_free_next;
        end
    end

    assign found           = found_reg;
    assign slot_index      = slot_index_reg;
    assign slot_trace_mask = slot_trace_reg;
    assign outcome         = outcome_reg;

endmodule

// ===== rtl/trace_cache_probe_table_core.sv =====
// trace cache probe table top level
// requests arrive on req and each one gives exactly one result item on res,
// in order; both channels move an item when valid and ready are high
// lookup and allocate read one slot of the window per cycle from the entry
// and valid memories, pipelined behind one read register; a hit returns as
// soon as its slot is compared, a miss, or an allocate that misses, once the
// whole window is checked, and either waits while the output register is full
// mark compiled sets the valid bit of the selected slot, flush all clears one
// valid bit per cycle, flush page reads and compares one entry per cycle and
// clears the valid bit of each valid entry on the same page
// one request is in work at a time; req.ready is high only between requests
// the result sits in an output register, so a new request is taken while
// the previous result waits; when res stalls, the next result holds the
// block until the output register frees
// after reset a clearing pass zeroes the valid memory and no request is
// taken until it ends
module trace_cache_probe_table_core #(
    parameter int TABLE_ENTRIES = tcpt_pkg::TABLE_ENTRIES_DEF,
    parameter int PROBE_DEPTH   = tcpt_pkg::PROBE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tcpt_req_if.sink   req,
    tcpt_res_if.source res
);

    tcpt_pkg::cmd_t cmd;
    tcpt_pkg::st_t  st;

    tcpt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PROBE_DEPTH   (PROBE_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .in_req_type (req.req_type),
        .out_valid   (res.valid),
        .out_ready   (res.ready),
        .cmd         (cmd),
        .st          (st)
    );

    tcpt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .req_type        (req.req_type),
        .phys_addr       (req.phys_addr),
        .fetch_mode      (req.fetch_mode),
        .trace_mask      (req.trace_mask),
        .slot_select     (req.slot_select),
        .found           (res.found),
        .slot_index      (res.slot_index),
        .slot_trace_mask (res.slot_trace_mask),
        .outcome         (res.outcome)
    );

endmodule

// ===== tb/tb_trace_cache_probe_table_core.sv =====
// self-checking testbench of the trace cache probe table core
`timescale 1ns / 100ps

module tb_trace_cache_probe_table_core;

    localparam int REQ_W      = tcpt_pkg::REQ_W;
    localparam int ADDR_W     = tcpt_pkg::ADDR_W;
    localparam int MODE_W     = tcpt_pkg::MODE_W;
    localparam int TRACE_W    = tcpt_pkg::TRACE_W;
    localparam int SEL_W      = tcpt_pkg::SEL_W;
    localparam int OUTCOME_W  = tcpt_pkg::OUTCOME_W;
    localparam int PAGE_SHIFT = tcpt_pkg::PAGE_SHIFT;
    localparam int HASH_SHIFT = tcpt_pkg::HASH_SHIFT;

    localparam int TABLE_SIZE   = tcpt_pkg::TABLE_ENTRIES_DEF;
    localparam int PROBE_SLOTS  = tcpt_pkg::PROBE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1400;
    localparam int POOL_KEYS    = 48;
    localparam int HOLD_CYCLES  = 1500;
    localparam int IDLE_LIMIT   = 4 * (HOLD_CYCLES + TABLE_SIZE + 100);

    localparam logic [REQ_W-1:0]  REQ_SPARE_FIRST = 3'd5;
    localparam logic [REQ_W-1:0]  REQ_SPARE_LAST  = 3'd7;
    localparam logic [ADDR_W-1:0] ADDR_ONES       = {ADDR_W{1'b1}};

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [ADDR_W-1:0]  addr;
        logic [MODE_W-1:0]  mode;
        logic [TRACE_W-1:0] trace;
        logic [SEL_W-1:0]   sel;
    } req_item_t;

    typedef struct packed {
        logic                 found;
        logic [SEL_W-1:0]     slot;
        logic [TRACE_W-1:0]   trace;
        logic [OUTCOME_W-1:0] outcome;
    } result_t;

    typedef struct {
        req_item_t item;
        bit        use_last;
        bit        typed;
        result_t   want;
    } dir_row_t;

    localparam result_t QUIET_RESULT = result_t'{1'b0, '0, '0, tcpt_pkg::OUT_DONE};

    logic clk = 1'b0;
    logic rst_n;

    tcpt_req_if req_if ();
    tcpt_res_if res_if ();

    trace_cache_probe_table_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if)
    );

    always #2 clk = ~clk;

    // shadow copy of the table
    logic [ADDR_W-1:0]  ent_addr  [TABLE_SIZE];
    logic [MODE_W-1:0]  ent_mode  [TABLE_SIZE];
    logic [TRACE_W-1:0] ent_trace [TABLE_SIZE];
    bit                 ent_valid [TABLE_SIZE];
    bit                 ent_written [TABLE_SIZE];
    logic [SEL_W-1:0]   written_slots [$];
    logic [SEL_W-1:0]   last_alloc;

    result_t   pending_results [$];
    dir_row_t  dir_rows [$];
    int        err_cnt      = 0;
    int        results_seen = 0;
    int        items_sent   = 0;
    int        burst_left   = 0;
    int        idle_cycles  = 0;

    logic [ADDR_W-1:0] pool_addr [POOL_KEYS];
    logic [MODE_W-1:0] pool_mode [POOL_KEYS];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_cnt < 50)
            $display("mismatch %0s: got %0h want %0h at result %0d", what, got, want,
                     results_seen);
        err_cnt++;
    endtask

    function automatic result_t table_apply(input req_item_t f);
        result_t           r;
        logic [ADDR_W-1:0] hsh;
        logic [SEL_W-1:0]  home;
        logic [SEL_W-1:0]  s;
        logic [SEL_W-1:0]  open_slot;
        bit                have_free;
        bit                hit;
        r = QUIET_RESULT;
        hsh = (f.addr >> HASH_SHIFT) ^ (f.addr >> PAGE_SHIFT) ^ ADDR_W'(f.mode);
        home = hsh[SEL_W-1:0];
        case (f.req)
            tcpt_pkg::REQ_LOOKUP, tcpt_pkg::REQ_ALLOC:
            begin
                have_free = 1'b0;
                hit = 1'b0;
                open_slot = home;
                for (int i = 0; i < PROBE_SLOTS; i++)
                begin
                    s = home + SEL_W'(i);
                    if (!hit && ent_valid[s] && ent_addr[s] == f.addr && ent_mode[s] == f.mode)
                    begin
                        hit = 1'b1;
                        r = result_t'{1'b1, s, ent_trace[s], tcpt_pkg::OUT_HIT};
                        if (f.req == tcpt_pkg::REQ_ALLOC)
                            last_alloc = s;
                    end
                    if (!hit && !ent_valid[s] && !have_free)
                    begin
                        have_free = 1'b1;
                        open_slot = s;
                    end
                end
                if (!hit && f.req == tcpt_pkg::REQ_ALLOC)
                begin
                    s = have_free ? open_slot : home;
                    ent_addr[s]  = f.addr;
                    ent_mode[s]  = f.mode;
                    ent_trace[s] = f.trace;
                    ent_valid[s] = 1'b0;
                    if (!ent_written[s])
                    begin
                        ent_written[s] = 1'b1;
                        written_slots.push_back(s);
                    end
                    last_alloc = s;
                    r = result_t'{1'b0, s, f.trace,
                                  have_free ? tcpt_pkg::OUT_FREE : tcpt_pkg::OUT_EVICT};
                end
            end
            tcpt_pkg::REQ_MARK:
                ent_valid[f.sel] = 1'b1;
            tcpt_pkg::REQ_FLUSH_ALL:
                for (int i = 0; i < TABLE_SIZE; i++)
                    ent_valid[i] = 1'b0;
            tcpt_pkg::REQ_FLUSH_PAGE:
                for (int i = 0; i < TABLE_SIZE; i++)
                    if (ent_valid[i] && ent_addr[i][ADDR_W-1:PAGE_SHIFT] == f.addr[ADDR_W-1:PAGE_SHIFT])
                        ent_valid[i] = 1'b0;
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic req_item_t any_request();
        req_item_t it;
        it.req   = tcpt_pkg::REQ_LOOKUP;
        it.addr  = ADDR_W'({$urandom, $urandom});
        it.mode  = $urandom;
        it.trace = $urandom;
        it.sel   = SEL_W'($urandom);
        return it;
    endfunction

    task automatic add_row(input logic [REQ_W-1:0] rq, input logic [ADDR_W-1:0] a,
                           input logic [MODE_W-1:0] m, input logic [TRACE_W-1:0] t,
                           input logic [SEL_W-1:0] s, input bit use_last, input bit typed,
                           input result_t want);
        dir_row_t row;
        row.item     = req_item_t'{rq, a, m, t, s};
        row.use_last = use_last;
        row.typed    = typed;
        row.want     = want;
        dir_rows.push_back(row);
    endtask

    task automatic send_item(input req_item_t f, input bit typed, input result_t want);
        int      gap;
        result_t pred;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 39) == 0)
                burst_left = $urandom_range(15, 40);
            gap = idle_len();
        end
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= f.req;
        req_if.phys_addr   <= f.addr;
        req_if.fetch_mode  <= f.mode;
        req_if.trace_mask  <= f.trace;
        req_if.slot_select <= f.sel;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pred = table_apply(f);
        pending_results.push_back(typed ? want : pred);
        if (f.req <= tcpt_pkg::REQ_FLUSH_PAGE)
            items_sent++;
    endtask

    // result side: random ready with one long hold-off
    initial
    begin : res_side
        int  run;
        int  gap;
        bit  held;
        held = 1'b0;
        res_if.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (!held && results_seen >= 300)
            begin
                held = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 6);
            res_if.ready <= 1'b1;
            repeat (run) @(posedge clk);
            gap = idle_len();
            if (gap > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : res_check
        result_t got;
        result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = result_t'{res_if.found, res_if.slot_index, res_if.slot_trace_mask,
                            res_if.outcome};
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending, slot", 64'(got.slot), 64'(0));
            else
            begin
                want = pending_results.pop_front();
                if (got.found !== want.found)
                    report_mismatch("found", 64'(got.found), 64'(want.found));
                if (got.slot !== want.slot)
                    report_mismatch("slot_index", 64'(got.slot), 64'(want.slot));
                if (got.trace !== want.trace)
                    report_mismatch("slot_trace_mask", 64'(got.trace), 64'(want.trace));
                if (got.outcome !== want.outcome)
                    report_mismatch("outcome", 64'(got.outcome), 64'(want.outcome));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        req_item_t                     it;
        int                            p;
        int                            pick;
        bit                            paused;
        logic [ADDR_W-PAGE_SHIFT-1:0]  pages [5];
        logic [SEL_W-1:0]              homes [4];
        logic [ADDR_W-1:0]             hsh;

        paused = 1'b0;
        rst_n = 1'b0;
        req_if.valid       = 1'b0;
        req_if.req_type    = tcpt_pkg::REQ_LOOKUP;
        req_if.phys_addr   = '0;
        req_if.fetch_mode  = '0;
        req_if.trace_mask  = '0;
        req_if.slot_select = '0;

        // key 0 homes at slot 0, the all-ones keys home at the last slot and wrap
        add_row(tcpt_pkg::REQ_LOOKUP, '0, '0, '0, '0, 0, 1, QUIET_RESULT);
        add_row(tcpt_pkg::REQ_ALLOC, '0, '0, '1, '1, 0, 1,
                result_t'{1'b0, '0, '1, tcpt_pkg::OUT_FREE});
        add_row(tcpt_pkg::REQ_LOOKUP, '0, '0, '0, '0, 0, 1, QUIET_RESULT);
        add_row(tcpt_pkg::REQ_MARK, '0, '0, '0, '0, 0, 1, QUIET_RESULT);
        add_row(tcpt_pkg::REQ_LOOKUP, '0, '0, '0, '0, 0, 1,
                result_t'{1'b1, '0, '1, tcpt_pkg::OUT_HIT});
        add_row(tcpt_pkg::REQ_ALLOC, '0, '0, '0, '0, 0, 1,
                result_t'{1'b1, '0, '1, tcpt_pkg::OUT_HIT});
        add_row(tcpt_pkg::REQ_ALLOC, ADDR_ONES, '1, '0, '0, 0, 1,
                result_t'{1'b0, SEL_W'(TABLE_SIZE - 1), '0, tcpt_pkg::OUT_FREE});
        add_row(tcpt_pkg::REQ_MARK, '0, '0, '0, SEL_W'(TABLE_SIZE - 1), 0, 1, QUIET_RESULT);
        add_row(tcpt_pkg::REQ_LOOKUP, ADDR_ONES, '1, '0, '0, 0, 1,
                result_t'{1'b1, SEL_W'(TABLE_SIZE - 1), '0, tcpt_pkg::OUT_HIT});
        // fill the wrapped window, then force an eviction of the home slot
        for (int n = 1; n <= 6; n++)
        begin
            add_row(tcpt_pkg::REQ_ALLOC, ADDR_ONES, MODE_W'(32'h3FF | (n << 16)), $urandom,
                    '0, 0, 0, QUIET_RESULT);
            add_row(tcpt_pkg::REQ_MARK, '0, '0, '0, '0, 1, 0, QUIET_RESULT);
        end
        add_row(tcpt_pkg::REQ_ALLOC, ADDR_ONES, MODE_W'(32'h3FF | (7 << 16)), $urandom, '0,
                0, 0, QUIET_RESULT);
        // page differing from key 0 only in the top page bit keeps key 0
        add_row(tcpt_pkg::REQ_FLUSH_PAGE, {1'b1, {(ADDR_W-1){1'b0}}}, '0, '0, '0, 0, 1,
                QUIET_RESULT);
        add_row(tcpt_pkg::REQ_LOOKUP, '0, '0, '0, '0, 0, 0, QUIET_RESULT);
        add_row(tcpt_pkg::REQ_FLUSH_PAGE, ADDR_ONES, '1, '1, '1, 0, 1, QUIET_RESULT);
        add_row(tcpt_pkg::REQ_FLUSH_ALL, '0, '0, '0, '0, 0, 1, QUIET_RESULT);
        add_row(tcpt_pkg::REQ_LOOKUP, '0, '0, '0, '0, 0, 1, QUIET_RESULT);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            it = dir_rows[i].item;
            if (dir_rows[i].use_last)
                it.sel = last_alloc;
            send_item(it, dir_rows[i].typed, dir_rows[i].want);
        end

        // key pool crowded onto a few home slots and pages
        for (int k = 0; k < 4; k++)
            pages[k] = (ADDR_W-PAGE_SHIFT)'({$urandom, $urandom});
        pages[4] = '1;
        homes[0] = SEL_W'($urandom);
        homes[1] = homes[0] + SEL_W'(3);
        homes[2] = SEL_W'(TABLE_SIZE - 2);
        homes[3] = SEL_W'($urandom);
        for (int k = 0; k < POOL_KEYS; k++)
        begin
            pool_addr[k] = {pages[$urandom_range(0, 4)], PAGE_SHIFT'($urandom)};
            pool_mode[k] = $urandom;
            hsh = (pool_addr[k] >> HASH_SHIFT) ^ (pool_addr[k] >> PAGE_SHIFT);
            pool_mode[k][SEL_W-1:0] = homes[k % 4] ^ hsh[SEL_W-1:0];
        end

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (!paused && items_sent >= RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                req_if.valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            it = any_request();
            p = $urandom_range(0, POOL_KEYS - 1);
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                // allocate, then usually compile and look up the same key, now and then allocate it again
                it.addr = pool_addr[p];
                it.mode = pool_mode[p];
                it.req = tcpt_pkg::REQ_ALLOC;
                send_item(it, 0, QUIET_RESULT);
                if ($urandom_range(0, 99) < 85)
                begin
                    it.req = tcpt_pkg::REQ_MARK;
                    it.sel = last_alloc;
                    send_item(it, 0, QUIET_RESULT);
                end
                if ($urandom_range(0, 99) < 70)
                begin
                    it.req = tcpt_pkg::REQ_LOOKUP;
                    it.trace = $urandom;
                    send_item(it, 0, QUIET_RESULT);
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    it.req = tcpt_pkg::REQ_ALLOC;
                    it.trace = $urandom;
                    send_item(it, 0, QUIET_RESULT);
                end
            end
            else if (pick < 73)
            begin
                it.addr = pool_addr[p];
                it.mode = pool_mode[p];
                it.req = (pick < 65) ? tcpt_pkg::REQ_LOOKUP : tcpt_pkg::REQ_ALLOC;
                send_item(it, 0, QUIET_RESULT);
            end
            else if (pick < 79)
            begin
                if (written_slots.size() == 0)
                    it.req = tcpt_pkg::REQ_LOOKUP;
                else
                begin
                    it.req = tcpt_pkg::REQ_MARK;
                    it.sel = written_slots[$urandom_range(0, written_slots.size() - 1)];
                end
                send_item(it, 0, QUIET_RESULT);
            end
            else if (pick < 81)
            begin
                it.req = tcpt_pkg::REQ_FLUSH_PAGE;
                if ($urandom_range(0, 9) < 7)
                    it.addr = {pool_addr[p][ADDR_W-1:PAGE_SHIFT], it.addr[PAGE_SHIFT-1:0]};
                send_item(it, 0, QUIET_RESULT);
            end
            else if (pick < 82)
            begin
                it.req = tcpt_pkg::REQ_FLUSH_ALL;
                send_item(it, 0, QUIET_RESULT);
            end
            else if (pick < 87)
            begin
                it.req = REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
                send_item(it, 0, QUIET_RESULT);
            end
            else
            begin
                it.req = ($urandom_range(0, 1) == 0) ? tcpt_pkg::REQ_LOOKUP
                                                     : tcpt_pkg::REQ_ALLOC;
                send_item(it, 0, QUIET_RESULT);
            end
        end
        req_if.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TABLE_SIZE + 16) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never returned", 64'(pending_results.size()), 64'(0));

        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== trace_cache_probe_table_core.f =====
rtl/tcpt_pkg.sv
rtl/tcpt_if.sv
rtl/tcpt_ctrl.sv
rtl/tcpt_dp.sv
rtl/trace_cache_probe_table_core.sv
tb/tb_trace_cache_probe_table_core.sv
